### hdl/ccfut_pkg.sv
// Shared types, constants and frame helpers for the command frame transmitter.
`timescale 1ns / 1ps
`default_nettype none

package ccfut_pkg;

  // Default number of data bits per serial character
  localparam int unsigned DataBitsDef = 8;

  // Configuration register indexes
  localparam logic RegBitPeriod = 1'b0;
  localparam logic RegGap       = 1'b1;

  // Configuration reset values
  localparam logic [15:0] BitPeriodRst = 16'd104;
  localparam logic [19:0] GapRst       = 20'd50000;

  // Fixed frame bytes
  localparam logic [7:0] FrameStart   = 8'h7E;
  localparam logic [7:0] FrameVersion = 8'hFF;
  localparam logic [7:0] FrameLength  = 8'h06;
  localparam logic [7:0] FrameNoFb    = 8'h00;
  localparam logic [7:0] FrameEnd     = 8'hEF;
  localparam logic [7:0] IdleByte     = 8'hFF;

  // Index of the last byte of a frame
  localparam logic [3:0] LastByte = 4'd9;

  // Byte positions within the frame
  localparam logic [3:0] PosStart   = 4'd0;
  localparam logic [3:0] PosVersion = 4'd1;
  localparam logic [3:0] PosLength  = 4'd2;
  localparam logic [3:0] PosCmd     = 4'd3;
  localparam logic [3:0] PosFb      = 4'd4;
  localparam logic [3:0] PosParHi   = 4'd5;
  localparam logic [3:0] PosParLo   = 4'd6;
  localparam logic [3:0] PosChkHi   = 4'd7;
  localparam logic [3:0] PosChkLo   = 4'd8;

  // Input request
  typedef struct packed {
    logic        cmd;
    logic [7:0]  command_code;
    logic [15:0] parameter_value;
  } ccfut_req_t;

  // Result item
  typedef struct packed {
    logic tx_line;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } ccfut_res_t;

  // Configuration register contents
  typedef struct packed {
    logic [15:0] bit_period;
    logic [19:0] gap;
  } ccfut_cfg_t;

  // Checksum: negated 16-bit sum of the six middle frame bytes
  function automatic logic [15:0] frame_checksum(input logic [7:0]  code,
                                                 input logic [15:0] param);
    logic [15:0] sum;
    sum = 16'(FrameVersion) + 16'(FrameLength) + 16'(code) + 16'(FrameNoFb)
        + 16'(param[15:8]) + 16'(param[7:0]);
    return 16'(~sum + 16'd1);
  endfunction

  // Byte of the frame at a given position
  function automatic logic [7:0] frame_byte(input logic [3:0]  pos,
                                            input logic [7:0]  code,
                                            input logic [15:0] param,
                                            input logic [15:0] chk);
    logic [7:0] b;
    unique case (pos)
      PosStart:   b = FrameStart;
      PosVersion: b = FrameVersion;
      PosLength:  b = FrameLength;
      PosCmd:     b = code;
      PosFb:      b = FrameNoFb;
      PosParHi:   b = param[15:8];
      PosParLo:   b = param[7:0];
      PosChkHi:   b = chk[15:8];
      PosChkLo:   b = chk[7:0];
      default:    b = FrameEnd;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/ccfut_regs.sv
// APB configuration registers: bit period and inter-frame gap.
`timescale 1ns / 1ps
`default_nettype none

module ccfut_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ccfut_pkg::ccfut_cfg_t     cfg_o
);
  import ccfut_pkg::*;

  logic [15:0] bit_period_q;
  logic [19:0] gap_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BitPeriodRst;
      gap_q        <= GapRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegBitPeriod: bit_period_q <= pwdata[15:0];
        RegGap:       gap_q        <= pwdata[19:0];
        default:      ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[2])
      RegBitPeriod: prdata = 32'(bit_period_q);
      RegGap:       prdata = 32'(gap_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.bit_period = bit_period_q;
  assign cfg_o.gap        = gap_q;

endmodule

`default_nettype wire

### hdl/ccfut_core.sv
// Framer and N1 serialiser state (8N1 with the default DATA_BITS), stepped once per request.
`timescale 1ns / 1ps
`default_nettype none

module ccfut_core #(
  parameter int unsigned DATA_BITS = ccfut_pkg::DataBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire ccfut_pkg::ccfut_req_t req_i,
  input  wire ccfut_pkg::ccfut_cfg_t cfg_i,
  output ccfut_pkg::ccfut_res_t     res_o
);
  import ccfut_pkg::*;

  // Bit position runs over start, data bits and stop
  localparam int unsigned BitPosW = $clog2(DATA_BITS + 2);
  localparam logic [BitPosW-1:0] LastData = BitPosW'(DATA_BITS);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhSend = 2'd1,
    PhGap  = 2'd2
  } ph_e;

  ph_e                phase_q, phase_d;
  logic [3:0]         byte_pos_q, byte_pos_d;
  logic [BitPosW-1:0] bit_pos_q, bit_pos_d;
  logic [15:0]        tick_q, tick_d;
  logic [19:0]        gap_cnt_q, gap_cnt_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [15:0]        param_q, param_d;
  logic [15:0]        chk_q, chk_d;
  logic [7:0]         shift_q, shift_d;
  logic               accepted, done;
  logic [15:0]        period, tick_inc;
  logic [19:0]        gap_inc;

  assign period   = (cfg_i.bit_period == '0) ? 16'd1 : cfg_i.bit_period;
  assign tick_inc = tick_q + 16'd1;
  assign gap_inc  = gap_cnt_q + 20'd1;

  // Next state for one request
  always_comb begin
    phase_d    = phase_q;
    byte_pos_d = byte_pos_q;
    bit_pos_d  = bit_pos_q;
    tick_d     = tick_q;
    gap_cnt_d  = gap_cnt_q;
    cmd_d      = cmd_q;
    param_d    = param_q;
    chk_d      = chk_q;
    shift_d    = shift_q;
    accepted   = 1'b0;
    done       = 1'b0;
    if (req_i.cmd) begin
      // Send request, taken only when idle
      if (phase_q != PhSend && phase_q != PhGap) begin
        cmd_d      = req_i.command_code;
        param_d    = req_i.parameter_value;
        chk_d      = frame_checksum(req_i.command_code, req_i.parameter_value);
        phase_d    = PhSend;
        byte_pos_d = '0;
        bit_pos_d  = '0;
        tick_d     = '0;
        gap_cnt_d  = '0;
        shift_d    = FrameStart;
        accepted   = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhSend: begin
          if (tick_inc >= period) begin
            tick_d = '0;
            if (bit_pos_q >= BitPosW'(1) && bit_pos_q <= LastData) begin
              shift_d = shift_q >> 1;
            end
            if (bit_pos_q <= LastData) begin
              bit_pos_d = bit_pos_q + BitPosW'(1);
            end else if (byte_pos_q < LastByte) begin
              byte_pos_d = byte_pos_q + 4'd1;
              bit_pos_d  = '0;
              shift_d    = frame_byte(byte_pos_q + 4'd1, cmd_q, param_q, chk_q);
            end else begin
              // Last stop bit over: into the gap or straight to idle
              bit_pos_d  = '0;
              byte_pos_d = '0;
              shift_d    = IdleByte;
              gap_cnt_d  = '0;
              if (cfg_i.gap == '0) begin
                phase_d = PhIdle;
                done    = 1'b1;
              end else begin
                phase_d = PhGap;
              end
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        PhGap: begin
          if (gap_inc >= cfg_i.gap) begin
            gap_cnt_d = '0;
            phase_d   = PhIdle;
            done      = 1'b1;
          end else begin
            gap_cnt_d = gap_inc;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  // Result reflects the state after the request
  always_comb begin
    res_o.busy_res   = (phase_d == PhSend) || (phase_d == PhGap);
    res_o.accepted   = accepted;
    res_o.frame_done = done;
    if (phase_d != PhSend) begin
      res_o.tx_line = 1'b1;
    end else if (bit_pos_d == '0) begin
      res_o.tx_line = 1'b0;
    end else if (bit_pos_d <= LastData) begin
      res_o.tx_line = shift_d[0];
    end else begin
      res_o.tx_line = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      byte_pos_q <= '0;
      bit_pos_q  <= '0;
      tick_q     <= '0;
      gap_cnt_q  <= '0;
      cmd_q      <= '0;
      param_q    <= '0;
      chk_q      <= '0;
      shift_q    <= IdleByte;
    end else if (step_i) begin
      phase_q    <= phase_d;
      byte_pos_q <= byte_pos_d;
      bit_pos_q  <= bit_pos_d;
      tick_q     <= tick_d;
      gap_cnt_q  <= gap_cnt_d;
      cmd_q      <= cmd_d;
      param_q    <= param_d;
      chk_q      <= chk_d;
      shift_q    <= shift_d;
    end
  end

endmodule

`default_nettype wire

### hdl/checksummed_command_frame_uart_tx.sv
// Top level: request register, framer/serialiser core, result register.
// Path: a request is held in the request register, passes the core and is captured in the result register.
// Throughput: one request per cycle while the output is not stalled; the core steps once per request.
// Stalls: the request register refills in the cycle the result register drains.
// Reset: asynchronous, active low; core idle, valids cleared, config at defaults; data registers not reset.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_command_frame_uart_tx #(
  parameter int unsigned DATA_BITS = ccfut_pkg::DataBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ccfut_pkg::ccfut_req_t in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ccfut_pkg::ccfut_res_t     out_res_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ccfut_pkg::*;

  logic       in_valid_q;
  ccfut_req_t in_req_q;
  logic       out_valid_q;
  ccfut_res_t out_res_q;
  ccfut_res_t res;
  ccfut_cfg_t cfg;
  logic       advance, in_take;

  ccfut_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccfut_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Pipeline handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTH
  // A taken request always starts with the start bit
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.accepted |-> out_res_o.busy_res && !out_res_o.tx_line)
    else $error("accepted request without start bit");

  // Frame completion leaves the block free
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.frame_done |-> !out_res_o.busy_res && !out_res_o.accepted)
    else $error("frame done while still busy");

  // Line idles high whenever not busy
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.busy_res |-> out_res_o.tx_line)
    else $error("line low while idle");

  // Input only stalls behind a held request
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
